// File: sv/tpat_pkg.sv
// Shared types, constants and status codes for the thermal preset autotune step.
// Used by tpat_csr, tpat_decide and thermal_preset_autotune_step; no dependencies.
package tpat_pkg;

   // Field widths
   localparam int TEMP_W    = 13;
   localparam int FAN_W     = 7;
   localparam int FREQ_W    = 10;
   localparam int VOLT_W    = 11;
   localparam int FREQ_NEW_W = 11;
   localparam int VOLT_NEW_W = 12;

   // Packed stream widths (whole bytes)
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   // Register port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ENABLE        = 3'd0,
      REG_PRESET_FREQ   = 3'd1,
      REG_PRESET_VOLT   = 3'd2,
      REG_PRESET_FAN    = 3'd3,
      REG_AUTO_FAN_MODE = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_DISABLED = 3'd0,
      ST_MISSING  = 3'd1,
      ST_IN_BAND  = 3'd2,
      ST_TOO_HOT  = 3'd3,
      ST_TOO_COLD = 3'd4
   } status_type;

   // Temperature band in 1/16 C: 60 C and 65 C
   localparam logic signed [TEMP_W-1:0] TEMP_LOW_Q4  = 13'sd960;
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH_Q4 = 13'sd1040;

   // Fan limits
   localparam logic [FAN_W-1:0] FAN_MAX          = 7'd100;
   localparam logic [FAN_W-1:0] FAN_PRESET_MIN   = 7'd18;
   localparam logic [FAN_W:0]   FAN_RAISE_MARGIN = 8'd5;
   localparam logic [FAN_W:0]   FAN_LOWER_MARGIN = 8'd3;

   // Band factors (percent of preset against 100)
   localparam logic [16:0] FREQ_HOT_BAND  = 17'd95;
   localparam logic [16:0] FREQ_COLD_BAND = 17'd105;
   localparam logic [16:0] FREQ_SCALE     = 17'd100;
   localparam logic [17:0] VOLT_HOT_BAND  = 18'd98;
   localparam logic [17:0] VOLT_COLD_BAND = 18'd102;
   localparam logic [17:0] VOLT_SCALE     = 18'd100;

   // Reciprocal multipliers: freq*49/50 and freq*51/50 as (freq*M) >> 20,
   // volt*499/500 and volt*501/500 as (volt*M) >> 21; exact over the input range.
   localparam int FREQ_SHIFT = 20;
   localparam int VOLT_SHIFT = 21;
   localparam logic [19:0] FREQ_DN_MUL = 20'd1027605;
   localparam logic [20:0] FREQ_UP_MUL = 21'd1069548;
   localparam logic [21:0] VOLT_DN_MUL = 22'd2092958;
   localparam logic [21:0] VOLT_UP_MUL = 22'd2101347;

   typedef struct packed {
      logic              enable;
      logic [FREQ_W-1:0] preset_freq_mhz;
      logic [VOLT_W-1:0] preset_voltage_mv;
      logic [FAN_W-1:0]  preset_fan_percent;
      logic              auto_fan_mode;
   } cfg_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature_q4;
      logic [FAN_W-1:0]         fan_percent;
      logic [FREQ_W-1:0]        freq_mhz;
      logic [VOLT_W-1:0]        target_voltage_mv;
      logic                     hashrate_nonzero;
      logic                     domain_voltage_nonzero;
   } sample_type;

   typedef struct packed {
      status_type            status;
      logic                  fan_write;
      logic [FAN_W-1:0]      fan_value;
      logic                  freq_write;
      logic [FREQ_NEW_W-1:0] freq_value;
      logic                  volt_write;
      logic [VOLT_NEW_W-1:0] volt_value;
   } result_type;

endpackage

// File: sv/tpat_csr.sv
// Configuration registers of the thermal preset autotune step.
// Depends on tpat_pkg for the register index codes and the cfg_type struct.
module tpat_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [tpat_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tpat_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tpat_pkg::cfg_type                cfg
);

   tpat_pkg::cfg_type cfg_ff;
   tpat_pkg::cfg_type cfg_in;

   // Decode the write; unknown indexes drop the word
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tpat_pkg::REG_ENABLE:
               cfg_in.enable = csr_wdata[0];
            tpat_pkg::REG_PRESET_FREQ:
               cfg_in.preset_freq_mhz = csr_wdata[tpat_pkg::FREQ_W-1:0];
            tpat_pkg::REG_PRESET_VOLT:
               cfg_in.preset_voltage_mv = csr_wdata[tpat_pkg::VOLT_W-1:0];
            tpat_pkg::REG_PRESET_FAN:
               cfg_in.preset_fan_percent = csr_wdata[tpat_pkg::FAN_W-1:0];
            tpat_pkg::REG_AUTO_FAN_MODE:
               cfg_in.auto_fan_mode = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Hold the registers; autotuning comes up enabled
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable             <= 1'b1;
         cfg_ff.preset_freq_mhz    <= '0;
         cfg_ff.preset_voltage_mv  <= '0;
         cfg_ff.preset_fan_percent <= '0;
         cfg_ff.auto_fan_mode      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/tpat_decide.sv
// Decision logic for one telemetry sample: status, fan, frequency and voltage.
// Depends on tpat_pkg for constants, status codes and the sample/result structs.
module tpat_decide (
   input  tpat_pkg::cfg_type    cfg,
   input  tpat_pkg::sample_type sample,
   output tpat_pkg::result_type result
);

   logic signed [tpat_pkg::TEMP_W-1:0] temp;
   logic                               missing;
   logic                               hot;
   logic                               cold;

   logic [tpat_pkg::FAN_W:0]   fan_ext;
   logic [tpat_pkg::FAN_W:0]   preset_fan_ext;
   logic [tpat_pkg::FAN_W:0]   fan_inc;
   logic                       fan_raise;
   logic                       fan_lower;
   logic [tpat_pkg::FAN_W-1:0] fan_up_value;
   logic [tpat_pkg::FAN_W-1:0] fan_dn_value;

   logic [16:0] freq_preset_hot;
   logic [16:0] freq_preset_cold;
   logic [16:0] freq_cur;
   logic [17:0] volt_preset_hot;
   logic [17:0] volt_preset_cold;
   logic [17:0] volt_cur;

   logic [29:0] freq_dn_prod;
   logic [30:0] freq_up_prod;
   logic [32:0] volt_dn_prod;
   logic [32:0] volt_up_prod;

   assign temp    = sample.temperature_q4;
   assign missing = (!sample.hashrate_nonzero || (sample.freq_mhz == '0) ||
                     !sample.domain_voltage_nonzero) && (temp < tpat_pkg::TEMP_HIGH_Q4);
   assign hot     = temp > tpat_pkg::TEMP_HIGH_Q4;
   assign cold    = temp < tpat_pkg::TEMP_LOW_Q4;

   // Fan step: raise near the preset, lower only with a high enough preset
   assign fan_ext        = {1'b0, sample.fan_percent};
   assign preset_fan_ext = {1'b0, cfg.preset_fan_percent};
   assign fan_inc        = fan_ext + 8'd1;
   assign fan_raise      = !cfg.auto_fan_mode &&
                           (fan_ext <= preset_fan_ext + tpat_pkg::FAN_RAISE_MARGIN);
   assign fan_lower      = !cfg.auto_fan_mode &&
                           (cfg.preset_fan_percent >= tpat_pkg::FAN_PRESET_MIN) &&
                           (fan_ext + tpat_pkg::FAN_LOWER_MARGIN >= preset_fan_ext);
   assign fan_up_value   = (fan_inc > {1'b0, tpat_pkg::FAN_MAX}) ? tpat_pkg::FAN_MAX
                                                                 : fan_inc[tpat_pkg::FAN_W-1:0];
   assign fan_dn_value   = sample.fan_percent - 7'd1;

   // Band checks as cross-multiplications against the preset
   assign freq_preset_hot  = 17'(cfg.preset_freq_mhz) * tpat_pkg::FREQ_HOT_BAND;
   assign freq_preset_cold = 17'(cfg.preset_freq_mhz) * tpat_pkg::FREQ_COLD_BAND;
   assign freq_cur         = 17'(sample.freq_mhz) * tpat_pkg::FREQ_SCALE;
   assign volt_preset_hot  = 18'(cfg.preset_voltage_mv) * tpat_pkg::VOLT_HOT_BAND;
   assign volt_preset_cold = 18'(cfg.preset_voltage_mv) * tpat_pkg::VOLT_COLD_BAND;
   assign volt_cur         = 18'(sample.target_voltage_mv) * tpat_pkg::VOLT_SCALE;

   // Scaled values through reciprocal multipliers
   assign freq_dn_prod = 30'(sample.freq_mhz) * 30'(tpat_pkg::FREQ_DN_MUL);
   assign freq_up_prod = 31'(sample.freq_mhz) * 31'(tpat_pkg::FREQ_UP_MUL);
   assign volt_dn_prod = 33'(sample.target_voltage_mv) * 33'(tpat_pkg::VOLT_DN_MUL);
   assign volt_up_prod = 33'(sample.target_voltage_mv) * 33'(tpat_pkg::VOLT_UP_MUL);

   // Pick the status and the writes; values stay zero without their write
   always_comb begin
      result = '0;
      if (!cfg.enable) begin
         result.status = tpat_pkg::ST_DISABLED;
      end else if (missing) begin
         result.status = tpat_pkg::ST_MISSING;
      end else if (hot) begin
         result.status = tpat_pkg::ST_TOO_HOT;
         if (fan_raise) begin
            result.fan_write = 1'b1;
            result.fan_value = fan_up_value;
         end else begin
            if (freq_preset_hot <= freq_cur) begin
               result.freq_write = 1'b1;
               result.freq_value = 11'(freq_dn_prod[29:tpat_pkg::FREQ_SHIFT]);
            end
            if (volt_preset_hot <= volt_cur) begin
               result.volt_write = 1'b1;
               result.volt_value = volt_dn_prod[32:tpat_pkg::VOLT_SHIFT];
            end
         end
      end else if (cold) begin
         result.status = tpat_pkg::ST_TOO_COLD;
         if (fan_lower) begin
            result.fan_write = 1'b1;
            result.fan_value = fan_dn_value;
         end else begin
            if (freq_preset_cold >= freq_cur) begin
               result.freq_write = 1'b1;
               result.freq_value = freq_up_prod[30:tpat_pkg::FREQ_SHIFT];
            end
            if (volt_preset_cold >= volt_cur) begin
               result.volt_write = 1'b1;
               result.volt_value = volt_up_prod[32:tpat_pkg::VOLT_SHIFT];
            end
         end
      end else begin
         result.status = tpat_pkg::ST_IN_BAND;
      end
   end

endmodule

// File: sv/thermal_preset_autotune_step.sv
// Top level of the thermal preset autotune step: input register, decision, result register.
// Depends on tpat_pkg, tpat_csr and tpat_decide.
//
//   channel  | direction | word
//   req_*    | in        | one telemetry sample
//   rsp_*    | out       | one adjustment decision per sample
//   csr_*    | in        | register write, no read-back
//
// One sample per cycle sustained while rsp_tready stays high. A word accepted into the input
// register passes through the decision into the result register, which raises rsp_tvalid;
// req accept and rsp accept are separated by the input register and the result register.
// Reset (synchronous, active high) empties both stages and loads the register defaults.
// A stalled rsp holds its word; the input stage still takes a word while the
// result register is waiting if the input stage itself is empty.
module thermal_preset_autotune_step (
   input  logic                             clock,
   input  logic                             reset,
   // temperature_q4[12:0], fan_percent[19:13], freq_mhz[29:20],
   // target_voltage_mv[40:30], hashrate_nonzero[41], domain_voltage_nonzero[42]
   input  logic [tpat_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // status[2:0], fan_write[3], fan_value[10:4], freq_write[11], freq_value[22:12],
   // volt_write[23], volt_value[35:24]
   output logic [tpat_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_wr_en,
   input  logic [tpat_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tpat_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tpat_pkg::cfg_type    cfg;
   tpat_pkg::sample_type req_sample;
   tpat_pkg::sample_type sample_ff;
   tpat_pkg::result_type result;
   tpat_pkg::result_type result_ff;

   logic in_valid_ff;
   logic in_valid_in;
   logic out_valid_ff;
   logic out_valid_in;
   logic out_free;
   logic advance;
   logic req_take;

   tpat_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Unpack the request word
   assign req_sample.temperature_q4         = req_tdata[12:0];
   assign req_sample.fan_percent            = req_tdata[19:13];
   assign req_sample.freq_mhz               = req_tdata[29:20];
   assign req_sample.target_voltage_mv      = req_tdata[40:30];
   assign req_sample.hashrate_nonzero       = req_tdata[41];
   assign req_sample.domain_voltage_nonzero = req_tdata[42];

   // Handshake: advance when the result register is empty or being drained
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   tpat_decide u_decide (
      .cfg    (cfg),
      .sample (sample_ff),
      .result (result)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_sample;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   // Pack the response word
   assign rsp_tvalid       = out_valid_ff;
   assign rsp_tdata[2:0]   = result_ff.status;
   assign rsp_tdata[3]     = result_ff.fan_write;
   assign rsp_tdata[10:4]  = result_ff.fan_value;
   assign rsp_tdata[11]    = result_ff.freq_write;
   assign rsp_tdata[22:12] = result_ff.freq_value;
   assign rsp_tdata[23]    = result_ff.volt_write;
   assign rsp_tdata[35:24] = result_ff.volt_value;
   assign rsp_tdata[39:36] = 4'd0;

endmodule
